// ----- rtl/ccvt_pkg.sv -----
// ----------------------------------------------------------------------------
// ccvt_pkg - shared types and constants of the camera pixel converter
// Pixel struct, source format codes, register indexes and the stage load
// strobes passed from the pipeline control to the datapath units.
// ----------------------------------------------------------------------------
`default_nettype none

package ccvt_pkg;

  // Source format codes held in the color_mode register
  typedef enum logic [1:0] {
    MODE_RGB24 = 2'd0,
    MODE_RGB32 = 2'd1,
    MODE_YUV   = 2'd2
  } color_mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_ENABLE = 1'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Load strobes of the decode stages
  typedef struct packed {
    logic s1;
    logic s2;
  } yuv_en_t;

  // Load strobes of the grayscale stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } gray_en_t;

endpackage

`default_nettype wire

// ----- rtl/ccvt_yuv.sv -----
// ----------------------------------------------------------------------------
// ccvt_yuv - pixel decode, stages 1 and 2
// Stage 1 forms the BT.601 constant products; stage 2 shifts, sums, clamps
// and picks the YUV result or the byte reorder.
// ----------------------------------------------------------------------------
`default_nettype none

module ccvt_yuv (
  input  wire logic              clk,
  input  wire ccvt_pkg::yuv_en_t en,
  input  wire logic [1:0]        color_mode,
  input  wire logic [7:0]        sample_a,
  input  wire logic [7:0]        sample_b,
  input  wire logic [7:0]        sample_c,
  output ccvt_pkg::rgb_t         rgb_o
);

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // Stage 1: offsets and constant products
  logic signed [8:0]  y_s;
  logic signed [7:0]  d_s;
  logic signed [7:0]  e_s;
  logic signed [17:0] py_nxt;
  logic signed [16:0] pe409_nxt;
  logic signed [14:0] pd100_nxt;
  logic signed [15:0] pe208_nxt;

  logic [7:0]         a_r, b_r, c_r;
  logic signed [17:0] py_r;
  logic signed [16:0] pe409_r;
  logic signed [14:0] pd100_r;
  logic signed [15:0] pe208_r;

  assign y_s = $signed({1'b0, sample_a}) - 9'sd16;
  assign d_s = $signed({~sample_b[7], sample_b[6:0]});
  assign e_s = $signed({~sample_c[7], sample_c[6:0]});

  assign py_nxt    = $signed({{9{y_s[8]}}, y_s}) * 18'sd298;
  assign pe409_nxt = $signed({{9{e_s[7]}}, e_s}) * 17'sd409;
  assign pd100_nxt = $signed({{7{d_s[7]}}, d_s}) * 15'sd100;
  assign pe208_nxt = $signed({{8{e_s[7]}}, e_s}) * 16'sd208;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a_r     <= sample_a;
      b_r     <= sample_b;
      c_r     <= sample_c;
      py_r    <= py_nxt;
      pe409_r <= pe409_nxt;
      pd100_r <= pd100_nxt;
      pe208_r <= pe208_nxt;
    end
  end

  // Stage 2: floor shifts by 8 are the upper bits of each product
  logic signed [11:0] alpha_w, e409_w, d100_w, e208_w, d2_w;
  logic signed [11:0] red_w, green_w, blue_w;
  logic [7:0]         d_r;
  ccvt_pkg::rgb_t     rgb_nxt;
  ccvt_pkg::rgb_t     rgb_r;

  assign d_r     = {~b_r[7], b_r[6:0]};
  assign alpha_w = $signed({{2{py_r[17]}}, py_r[17:8]});
  assign e409_w  = $signed({{3{pe409_r[16]}}, pe409_r[16:8]});
  assign d100_w  = $signed({{5{pd100_r[14]}}, pd100_r[14:8]});
  assign e208_w  = $signed({{4{pe208_r[15]}}, pe208_r[15:8]});
  assign d2_w    = $signed({{3{d_r[7]}}, d_r, 1'b0});

  assign red_w   = alpha_w + e409_w;
  assign green_w = alpha_w - d100_w - e208_w;
  assign blue_w  = alpha_w + d2_w;

  always_comb begin
    case (color_mode)
      ccvt_pkg::MODE_YUV: begin
        rgb_nxt.red   = clamp8(red_w);
        rgb_nxt.green = clamp8(green_w);
        rgb_nxt.blue  = clamp8(blue_w);
      end
      ccvt_pkg::MODE_RGB24, ccvt_pkg::MODE_RGB32: begin
        rgb_nxt.red   = c_r;
        rgb_nxt.green = b_r;
        rgb_nxt.blue  = a_r;
      end
      default: begin
        rgb_nxt.red   = c_r;
        rgb_nxt.green = b_r;
        rgb_nxt.blue  = a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign rgb_o = rgb_r;

endmodule

`default_nettype wire

// ----- rtl/ccvt_gray.sv -----
// ----------------------------------------------------------------------------
// ccvt_gray - grayscale weighting, stages 3 to 5
// Stage 3 weights, stage 4 divides each term by 100, stage 5 sums,
// saturates and selects gray or the color pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ccvt_gray (
  input  wire logic               clk,
  input  wire ccvt_pkg::gray_en_t en,
  input  wire logic               gray_enable,
  input  wire ccvt_pkg::rgb_t     rgb_i,
  output ccvt_pkg::rgb_t          rgb_o
);

  // floor(x / 100) == (x * 5243) >> 19 for x below 43690
  localparam logic [12:0] DIV100_MUL = 13'd5243;

  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(DIV100_MUL);
    return p[26:19];
  endfunction

  // Stage 3: weights
  ccvt_pkg::rgb_t s3_rgb_r;
  logic [12:0]    wr_r;
  logic [13:0]    wg_r;
  logic [11:0]    wb_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_rgb_r <= rgb_i;
      wr_r     <= 13'(rgb_i.red)   * 13'd30;
      wg_r     <= 14'(rgb_i.green) * 14'd59;
      wb_r     <= 12'(rgb_i.blue)  * 12'd11;
    end
  end

  // Stage 4: truncated division of each term
  ccvt_pkg::rgb_t s4_rgb_r;
  logic [7:0]     qr_r, qg_r, qb_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_rgb_r <= s3_rgb_r;
      qr_r     <= div100(14'(wr_r));
      qg_r     <= div100(wg_r);
      qb_r     <= div100(14'(wb_r));
    end
  end

  // Stage 5: sum, saturate, select
  logic [9:0]     sum_w;
  logic [7:0]     gray_w;
  ccvt_pkg::rgb_t rgb_nxt;
  ccvt_pkg::rgb_t rgb_r;

  assign sum_w  = 10'(qr_r) + 10'(qg_r) + 10'(qb_r);
  assign gray_w = (sum_w > 10'd255) ? 8'd255 : sum_w[7:0];

  always_comb begin
    if (gray_enable) begin
      rgb_nxt.red   = gray_w;
      rgb_nxt.green = gray_w;
      rgb_nxt.blue  = gray_w;
    end else begin
      rgb_nxt = s4_rgb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign rgb_o = rgb_r;

endmodule

`default_nettype wire

// ----- rtl/camera_pixel_to_rgb24_converter.sv -----
// ----------------------------------------------------------------------------
// camera_pixel_to_rgb24_converter - camera pixel to RGB24 stream converter
// Five-stage pipeline: byte reorder or integer BT.601 YUV decode, then an
// optional 30/59/11 percent grayscale weighting.
// ----------------------------------------------------------------------------
// One pixel enters per item and one RGB24 pixel leaves per item, in order.
// The block takes one item every clock cycle while the output side is ready
// and passes each result through the five register stages (products,
// decode/clamp, weights, divide by 100, gray sum/select). Each stage has
// its own valid bit and a stage loads whenever it is empty or the stage
// after it moves, so bubbles close up and input is taken while a finished
// result waits at the output as long as some stage is empty. Program
// color_mode and gray_enable only while no item is in flight. color_mode 3
// behaves as a plain byte reorder.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_pixel_to_rgb24_converter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [ccvt_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [ccvt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input pixel stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,  // sample_a, sample_b, sample_c
  input  wire logic                          in_tlast,  // frame_end
  // output pixel stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [23:0]                        out_tdata, // red, green, blue
  output logic                               out_tlast  // frame_last
);

  localparam int unsigned DEPTH = 5;

  // Configuration registers
  logic [1:0] color_mode_r;
  logic       gray_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r  <= ccvt_pkg::MODE_RGB24;
      gray_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ccvt_pkg::CFG_COLOR_MODE:  color_mode_r  <= cfg_wdata[1:0];
        ccvt_pkg::CFG_GRAY_ENABLE: gray_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage is ready when empty or when the next moves
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] last_r;
  logic [DEPTH-1:0] stage_rdy;
  logic [DEPTH-1:0] valid_in;
  logic [DEPTH-1:0] last_in;
  logic [DEPTH-1:0] load;

  assign valid_in = {valid_r[DEPTH-2:0], in_tvalid};
  assign last_in  = {last_r[DEPTH-2:0], in_tlast};

  always_comb begin
    stage_rdy[DEPTH-1] = !valid_r[DEPTH-1] || out_tready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      stage_rdy[k] = !valid_r[k] || stage_rdy[k+1];
    end
  end

  // Load payload only when a real item moves in
  assign load = stage_rdy & valid_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (stage_rdy[k]) begin
          valid_r[k] <= valid_in[k];
        end
      end
    end
  end

  // Frame mark travels beside the pixel
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (load[k]) begin
        last_r[k] <= last_in[k];
      end
    end
  end

  ccvt_pkg::yuv_en_t  yuv_en;
  ccvt_pkg::gray_en_t gray_en;
  ccvt_pkg::rgb_t     dec_rgb;
  ccvt_pkg::rgb_t     res_rgb;

  assign yuv_en.s1  = load[0];
  assign yuv_en.s2  = load[1];
  assign gray_en.s3 = load[2];
  assign gray_en.s4 = load[3];
  assign gray_en.s5 = load[4];

  // Stages 1-2: decode to RGB
  ccvt_yuv u_yuv (
    .clk        (clk),
    .en         (yuv_en),
    .color_mode (color_mode_r),
    .sample_a   (in_tdata[7:0]),
    .sample_b   (in_tdata[15:8]),
    .sample_c   (in_tdata[23:16]),
    .rgb_o      (dec_rgb)
  );

  // Stages 3-5: optional grayscale
  ccvt_gray u_gray (
    .clk         (clk),
    .en          (gray_en),
    .gray_enable (gray_enable_r),
    .rgb_i       (dec_rgb),
    .rgb_o       (res_rgb)
  );

  assign in_tready  = stage_rdy[0];
  assign out_tvalid = valid_r[DEPTH-1];
  assign out_tlast  = last_r[DEPTH-1];
  assign out_tdata  = {res_rgb.blue, res_rgb.green, res_rgb.red};

  // An empty output stage means the whole chain can take an item
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage is empty");

  // With the output held ready, an accepted item must come out of the last stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      ##1 out_tready |=> out_tvalid)
    else $error("accepted item did not reach the output in time");

  // Output valid cannot appear from an empty pipeline
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r == '0) && !in_tvalid |=> !out_tvalid)
    else $error("result appeared with no item in flight");

endmodule

`default_nettype wire

// ----- bench/tb_camera_pixel_to_rgb24_converter.sv -----
// ----------------------------------------------------------------------------
// tb_camera_pixel_to_rgb24_converter - regression bench of the pixel converter
// Drives camera pixels through every source format, with and without the
// grayscale stage, checks each RGB24 item against a local conversion model
// or a directed expected value, and throttles both stream sides at random.
// ----------------------------------------------------------------------------
module tb_camera_pixel_to_rgb24_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS   = 1030;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned MAX_IDLE       = 10;
  // Five register stages; idle wait after the drain, before touching registers
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_REPORTS    = 10;
  // Slowest run: ~1100 items with the longest gaps and stalls, plus drains, x10
  localparam int unsigned TIMEOUT_CYCLES = 300000;

  // One converted pixel as it leaves the block
  typedef struct packed {
    ccvt_pkg::rgb_t px;
    logic           last;
  } pixel_res_t;

  // One row of the directed table
  typedef struct packed {
    logic [1:0]     mode;
    logic [1:0]     gray;
    logic [7:0]     a;
    logic [7:0]     b;
    logic [7:0]     c;
    logic           last;
    logic           typed;
    ccvt_pkg::rgb_t px_exp;
  } pixel_vec_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ccvt_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [ccvt_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [23:0]                     in_tdata;   // sample_a, sample_b, sample_c
  logic                            in_tlast;   // frame_end
  logic                            out_tvalid;
  logic                            out_tready;
  logic [23:0]                     out_tdata;  // red, green, blue
  logic                            out_tlast;  // frame_last

  // Model copy of the registers and the last raw values written
  logic [1:0]  mode_q;
  logic        gray_q;
  logic [1:0]  wr_mode;
  logic [1:0]  wr_gray;

  pixel_res_t  pending_pixels[$];
  pixel_vec_t  directed_rows[$];

  int unsigned cycles;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned frames_sent;
  int unsigned reg_writes;
  int unsigned mismatches;

  camera_pixel_to_rgb24_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop if the pipeline hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d pixels still outstanding",
               cycles, pending_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Conversion model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Decode one pixel under the current register settings. The >>> on a
  // signed int floors, which is exactly the shift the BT.601 math wants.
  function automatic pixel_res_t convert_pixel(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic last);
    int         luma;
    int         cb;
    int         cr;
    int         alpha;
    int         gray;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] bl;
    pixel_res_t res;
    if (mode_q == ccvt_pkg::MODE_YUV) begin
      luma  = int'(a) - 16;
      cb    = int'(b) - 128;
      cr    = int'(c) - 128;
      alpha = (luma * 298) >>> 8;
      r     = clamp_byte(alpha + ((cr * 409) >>> 8));
      g     = clamp_byte(alpha - ((cb * 100) >>> 8) - ((cr * 208) >>> 8));
      bl    = clamp_byte(alpha + 2 * cb);
    end else begin
      // Both reorder modes and the unused code swap first and third byte
      r  = c;
      g  = b;
      bl = a;
    end
    if (gray_q) begin
      // Each weighted term truncates on its own
      gray = (int'(r) * 30) / 100 + (int'(g) * 59) / 100 + (int'(bl) * 11) / 100;
      if (gray > 255) gray = 255;
      r  = gray[7:0];
      g  = gray[7:0];
      bl = gray[7:0];
    end
    res.px.red   = r;
    res.px.green = g;
    res.px.blue  = bl;
    res.last     = last;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one pixel after a random gap (none when quiet) and hold it until taken
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                            input logic last, input logic typed,
                            input ccvt_pkg::rgb_t px_exp, input bit quiet);
    int unsigned gap;
    pixel_res_t  want;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c, b, a};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    // Item taken at this edge; registers cannot change while it is in flight
    want = convert_pixel(a, b, c, last);
    if (typed) want.px = px_exp;
    pending_pixels.push_back(want);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Drain the pipeline, then write both registers
  task automatic program_regs(input logic [1:0] mode, input logic [1:0] gray);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= ccvt_pkg::CFG_COLOR_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    // Upper data bit must be ignored by the one-bit register
    cfg_addr  <= ccvt_pkg::CFG_GRAY_ENABLE;
    cfg_wdata <= gray;
    @(posedge clk);
    cfg_we  <= 1'b0;
    mode_q  = mode;
    gray_q  = gray[0];
    wr_mode = mode;
    wr_gray = gray;
    reg_writes += 2;
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [1:0] gray,
                         input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                         input logic last, input logic typed,
                         input logic [7:0] er, input logic [7:0] eg, input logic [7:0] eb);
    pixel_vec_t v;
    v.mode  = mode;
    v.gray  = gray;
    v.a     = a;
    v.b     = b;
    v.c     = c;
    v.last  = last;
    v.typed = typed;
    v.px_exp.red   = er;
    v.px_exp.green = eg;
    v.px_exp.blue  = eb;
    directed_rows.push_back(v);
  endtask

  // Bias toward the corners of the YUV space and the byte extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'd16;
      3: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [1:0]     mode;
    logic [1:0]     gray;
    bit             quiet;
    ccvt_pkg::rgb_t none;
    pixel_vec_t     v;

    none       = '0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    cycles         = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    frames_sent    = 0;
    reg_writes     = 0;
    mismatches     = 0;
    // Registers come out of reset as rgb24 swap, grayscale off
    mode_q  = ccvt_pkg::MODE_RGB24;
    gray_q  = 1'b0;
    wr_mode = ccvt_pkg::MODE_RGB24;
    wr_gray = 2'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: mode, gray, a, b, c, last, typed, red, green, blue.
    // Leading rows run on the reset values, no register write in between.
    add_row(ccvt_pkg::MODE_RGB24, 2'd0, 8'h01, 8'h02, 8'h03, 1'b0, 1'b1, 8'h03, 8'h02, 8'h01);
    add_row(ccvt_pkg::MODE_RGB24, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_RGB24, 2'd0, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 8'hff, 8'hff, 8'hff);
    add_row(ccvt_pkg::MODE_RGB24, 2'd0, 8'h80, 8'h7f, 8'h01, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_RGB32, 2'd0, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 8'h56, 8'h34, 8'h12);
    add_row(ccvt_pkg::MODE_RGB32, 2'd0, 8'hff, 8'h00, 8'hff, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    // Unused mode code falls back to the byte reorder
    add_row(2'd3, 2'd0, 8'haa, 8'h55, 8'hf0, 1'b0, 1'b1, 8'hf0, 8'h55, 8'haa);
    add_row(2'd3, 2'd0, 8'h00, 8'hff, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    // YUV: video black and video white with neutral chroma
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd16, 8'd128, 8'd128, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd235, 8'd128, 8'd128, 1'b0, 1'b1,
            8'd254, 8'd254, 8'd254);
    // YUV corners: clamp at both ends, negative floor shifts
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd128, 8'd0,   8'd255, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_YUV, 2'd0, 8'd128, 8'd255, 8'd0,   1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    // Grayscale after YUV decode
    add_row(ccvt_pkg::MODE_YUV, 2'd1, 8'd255, 8'd128, 8'd128, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(ccvt_pkg::MODE_YUV, 2'd1, 8'd81,  8'd90,  8'd240, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    // Gray write with the spare data bit set still enables grayscale
    add_row(ccvt_pkg::MODE_YUV, 2'd3, 8'd16,  8'd128, 8'd128, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0);
    // Full-white gray: 76 + 150 + 28
    add_row(ccvt_pkg::MODE_RGB24, 2'd1, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1,
            8'd254, 8'd254, 8'd254);
    add_row(ccvt_pkg::MODE_RGB24, 2'd1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0);
    add_row(ccvt_pkg::MODE_RGB32, 2'd1, 8'hc8, 8'h64, 8'h32, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_row(2'd3, 2'd1, 8'hff, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    // Spare data bit alone leaves grayscale off
    add_row(ccvt_pkg::MODE_RGB24, 2'd2, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'hff);

    foreach (directed_rows[i]) begin
      v = directed_rows[i];
      if (v.mode !== wr_mode || v.gray !== wr_gray) program_regs(v.mode, v.gray);
      send_pixel(v.a, v.b, v.c, v.last, v.typed, v.px_exp, 1'b0);
    end

    // Random phases: every mode with gray off, then on, then with random gray settings
    for (int p = 0; p < PHASES; p++) begin
      mode = 2'(p % 4);
      gray = (p < 8) ? 2'(p / 4) : 2'($urandom_range(0, 3));
      program_regs(mode, gray);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_pixel(pick_byte(), pick_byte(), pick_byte(),
                   ($urandom_range(0, 15) == 0), 1'b0, none, quiet);
      end
    end

    // Wait out the pipeline, then idle to catch stray items
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels in %0d frames, checked %0d results, %0d register writes.",
             pixels_sent, frames_sent, pixels_checked, reg_writes);
    $display("Formats rgb24, rgb32, unused code and yuv, each with and without gray.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  // Stall a random time before each item; now and then run a stretch with ready held high
  initial begin
    int unsigned stall;
    int unsigned stretch;
    bit          quiet;
    out_tready <= 1'b0;
    stretch = 0;
    quiet   = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stretch = 50;
        quiet   = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each taken item with the oldest outstanding pixel
  always @(posedge clk) begin
    pixel_res_t want;
    pixel_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.px.red   = out_tdata[7:0];
      got.px.green = out_tdata[15:8];
      got.px.blue  = out_tdata[23:16];
      got.last     = out_tlast;
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected item rgb %h %h %h last %b", $realtime,
                   got.px.red, got.px.green, got.px.blue, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
            got.px.blue !== want.px.blue || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel %0d exp rgb %h %h %h last %b, got %h %h %h last %b",
                     $realtime, pixels_checked, want.px.red, want.px.green,
                     want.px.blue, want.last, got.px.red, got.px.green, got.px.blue,
                     got.last);
        end
      end
    end
  end

endmodule
